// ----- src/assert_macros.svh -----
// Assertion macros used by the queue datapath; clock and reset are the module's own ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/terq_pkg.sv -----
// Shared constants, register codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package terq_pkg;

   localparam int QUEUE_DEPTH  = 256;
   localparam int CONTROL_BITS = 32;

   localparam int IDX_W    = $clog2(QUEUE_DEPTH);
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int WORD_W   = 32;
   localparam int CTRL_W   = (CONTROL_BITS < WORD_W) ? CONTROL_BITS : WORD_W;
   localparam int TIME_W   = 48;
   localparam int FRAC_W   = 32;
   localparam int STEP_W   = 20;
   localparam int LIMIT_W  = 16;
   localparam int COUNT_W  = 9;
   localparam int TOTAL_W  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic [STEP_W-1:0]  STEP_WHOLE_RESET    = 20'd22;
   localparam logic [FRAC_W-1:0]  STEP_FRACTION_RESET = 32'd2902268131;
   localparam logic [LIMIT_W-1:0] LATE_LIMIT_RESET    = 16'd1000;
   localparam logic [TIME_W-1:0]  START_TIME_RESET    = 48'd0;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_WHOLE    = 2'd0,
      CSR_STEP_FRACTION = 2'd1,
      CSR_LATE_LIMIT    = 2'd2,
      CSR_START_TIME    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic capture;     // input transfer: latch payload, clear per-tick counts
      logic do_push;     // store the event, drop oldest if full
      logic do_apply;    // apply the event at the head
      logic do_advance;  // step the render clock
      logic load_out;    // load the result register
   } terq_cmd_type;

   typedef struct packed {
      logic event_due;   // head entry exists and is at or before the render clock
   } terq_status_type;

endpackage

`default_nettype wire

// ----- src/terq_ctrl.sv -----
// Sequencer for push and tick items, and the result-valid flag.
`timescale 1ns / 1ps
`default_nettype none

module terq_ctrl
   import terq_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_cmd,
   output logic                 req_stall,
   input  wire logic            rsp_stall,
   output logic                 rsp_valid,
   input  wire terq_status_type status,
   output terq_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_cmd == CMD_TICK) ? ST_DRAIN : ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               cmd.do_push  = 1'b1;
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            // one due event per cycle; finish once the head is not due and the result register is free
            if (status.event_due) begin
               cmd.do_apply = 1'b1;
            end else if (out_free) begin
               cmd.do_advance = 1'b1;
               cmd.load_out   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/terq_dp.sv -----
// Event ring memory, queue pointers, render clock, totals and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module terq_dp
   import terq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire terq_cmd_type          cmd,
   output terq_status_type            status,
   input  wire logic [WORD_W-1:0]     req_control_word,
   input  wire logic [TIME_W-1:0]     req_event_time_us,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic [WORD_W-1:0]          rsp_current_control,
   output logic [TIME_W-1:0]          rsp_render_time_us,
   output logic [COUNT_W-1:0]         rsp_applied_now,
   output logic [COUNT_W-1:0]         rsp_late_now,
   output logic [COUNT_W-1:0]         rsp_queue_count,
   output logic [COUNT_W-1:0]         rsp_peak_count,
   output logic                       rsp_overrun,
   output logic [TOTAL_W-1:0]         rsp_overrun_total,
   output logic [TOTAL_W-1:0]         rsp_late_total,
   output logic [TOTAL_W-1:0]         rsp_received_total,
   output logic [TOTAL_W-1:0]         rsp_applied_total
);

   localparam int SUM_W = IDX_W + 1;

   // ring storage
   logic [CTRL_W-1:0] word_mem [QUEUE_DEPTH];
   logic [TIME_W-1:0] time_mem [QUEUE_DEPTH];
   logic [CTRL_W-1:0] rd_word_ff;
   logic [TIME_W-1:0] rd_time_ff;

   // captured input
   logic [CTRL_W-1:0] in_word_ff;
   logic [TIME_W-1:0] in_time_ff;

   // configuration
   logic [STEP_W-1:0]  step_whole_ff, step_whole_in;
   logic [FRAC_W-1:0]  step_frac_ff, step_frac_in;
   logic [LIMIT_W-1:0] late_limit_ff, late_limit_in;

   // queue and clock state
   logic [IDX_W-1:0]   head_ff, head_in, head_next, tail;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]   peak_ff, peak_in;
   logic [TIME_W-1:0]  clock_ff, clock_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [CTRL_W-1:0]  active_ff, active_in;
   logic [CNT_W-1:0]   applied_now_ff, applied_now_in;
   logic [CNT_W-1:0]   late_now_ff, late_now_in;
   logic [TOTAL_W-1:0] dropped_ff, dropped_in;
   logic [TOTAL_W-1:0] late_tot_ff, late_tot_in;
   logic [TOTAL_W-1:0] pushed_ff, pushed_in;
   logic [TOTAL_W-1:0] released_ff, released_in;

   logic              full;
   logic              is_late;
   logic              overrun;
   logic [TIME_W-1:0] lag;
   logic [FRAC_W:0]   frac_sum;
   logic [SUM_W-1:0]  tail_sum, tail_wrap;

   assign full      = (occ_ff == CNT_W'(QUEUE_DEPTH));
   assign head_next = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(occ_ff);
   assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      tail_sum - SUM_W'(QUEUE_DEPTH) : tail_sum;
   // when full the new entry lands where the dropped oldest one was
   assign tail      = full ? head_ff : tail_wrap[IDX_W-1:0];
   assign lag       = clock_ff - rd_time_ff;
   assign is_late   = (lag > TIME_W'(late_limit_ff));
   assign frac_sum  = {1'b0, frac_ff} + {1'b0, step_frac_ff};
   assign overrun   = cmd.do_push && full;

   assign status.event_due = (occ_ff != '0) && (rd_time_ff <= clock_ff);

   always_comb begin
      step_whole_in  = step_whole_ff;
      step_frac_in   = step_frac_ff;
      late_limit_in  = late_limit_ff;
      head_in        = head_ff;
      occ_in         = occ_ff;
      peak_in        = peak_ff;
      clock_in       = clock_ff;
      frac_in        = frac_ff;
      active_in      = active_ff;
      applied_now_in = applied_now_ff;
      late_now_in    = late_now_ff;
      dropped_in     = dropped_ff;
      late_tot_in    = late_tot_ff;
      pushed_in      = pushed_ff;
      released_in    = released_ff;

      if (cmd.capture) begin
         applied_now_in = '0;
         late_now_in    = '0;
      end

      if (cmd.do_push) begin
         if (full) begin
            head_in    = head_next;
            dropped_in = dropped_ff + 1'b1;
         end else begin
            occ_in = occ_ff + 1'b1;
         end
         pushed_in = pushed_ff + 1'b1;
         peak_in   = (occ_in > peak_ff) ? occ_in : peak_ff;
      end

      if (cmd.do_apply) begin
         active_in      = rd_word_ff;
         applied_now_in = applied_now_ff + 1'b1;
         released_in    = released_ff + 1'b1;
         head_in        = head_next;
         occ_in         = occ_ff - 1'b1;
         if (is_late) begin
            late_now_in = late_now_ff + 1'b1;
            late_tot_in = late_tot_ff + 1'b1;
         end
      end

      if (cmd.do_advance) begin
         clock_in = clock_ff + TIME_W'(step_whole_ff) + TIME_W'(frac_sum[FRAC_W]);
         frac_in  = frac_sum[FRAC_W-1:0];
      end

      if (csr_write) begin
         unique case (csr_index)
            CSR_STEP_WHOLE:    step_whole_in = csr_data[STEP_W-1:0];
            CSR_STEP_FRACTION: step_frac_in  = csr_data[FRAC_W-1:0];
            CSR_LATE_LIMIT:    late_limit_in = csr_data[LIMIT_W-1:0];
            CSR_START_TIME: begin
               clock_in = csr_data[TIME_W-1:0];
               frac_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_whole_ff  <= STEP_WHOLE_RESET;
         step_frac_ff   <= STEP_FRACTION_RESET;
         late_limit_ff  <= LATE_LIMIT_RESET;
         head_ff        <= '0;
         occ_ff         <= '0;
         peak_ff        <= '0;
         clock_ff       <= START_TIME_RESET;
         frac_ff        <= '0;
         active_ff      <= '0;
         applied_now_ff <= '0;
         late_now_ff    <= '0;
         dropped_ff     <= '0;
         late_tot_ff    <= '0;
         pushed_ff      <= '0;
         released_ff    <= '0;
      end else begin
         step_whole_ff  <= step_whole_in;
         step_frac_ff   <= step_frac_in;
         late_limit_ff  <= late_limit_in;
         head_ff        <= head_in;
         occ_ff         <= occ_in;
         peak_ff        <= peak_in;
         clock_ff       <= clock_in;
         frac_ff        <= frac_in;
         active_ff      <= active_in;
         applied_now_ff <= applied_now_in;
         late_now_ff    <= late_now_in;
         dropped_ff     <= dropped_in;
         late_tot_ff    <= late_tot_in;
         pushed_ff      <= pushed_in;
         released_ff    <= released_in;
      end
   end

   // ring memory: read follows the next head so the head entry is ready each cycle
   always_ff @(posedge clock) begin
      if (cmd.do_push) begin
         word_mem[tail] <= in_word_ff;
         time_mem[tail] <= in_time_ff;
      end
      rd_word_ff <= word_mem[head_in];
      rd_time_ff <= time_mem[head_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_word_ff <= req_control_word[CTRL_W-1:0];
         in_time_ff <= req_event_time_us;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_current_control <= WORD_W'(active_in);
         rsp_render_time_us  <= clock_ff;
         rsp_applied_now     <= COUNT_W'(applied_now_in);
         rsp_late_now        <= COUNT_W'(late_now_in);
         rsp_queue_count     <= COUNT_W'(occ_in);
         rsp_peak_count      <= COUNT_W'(peak_in);
         rsp_overrun         <= overrun;
         rsp_overrun_total   <= dropped_in;
         rsp_late_total      <= late_tot_in;
         rsp_received_total  <= pushed_in;
         rsp_applied_total   <= released_in;
      end
   end

   `ASSERT_ALWAYS(a_occ_bound, occ_ff <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
   `ASSERT_ALWAYS(a_peak_covers, peak_ff >= occ_ff, "peak below occupancy")
   `ASSERT_IMPLIES(a_apply_nonempty, cmd.do_apply, occ_ff != '0, "apply on empty queue")
   `ASSERT_NEXT(a_push_fills, cmd.do_push, occ_ff != '0, "queue empty after push")

endmodule

`default_nettype wire

// ----- src/timestamped_event_release_queue_core.sv -----
// Top level of the timestamped event release queue: sequencer plus datapath.
//
//  channel  dir  handshake              payload
//  req      in   req_valid / req_stall  req_cmd, req_control_word, req_event_time_us
//  rsp      out  rsp_valid / rsp_stall  current control, render time, counts, totals
//  csr      in   csr_write              csr_index, csr_data (no read-back)
//
// A push goes from transfer through the push state to the result register; a tick applies
// its due events one per cycle through the ring memory's registered read port.
// A new item is taken only while the sequencer is idle; a waiting result does not block it.
// A stalled result holds the finishing step until the result register frees up.
// Reset is synchronous; the ring memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module timestamped_event_release_queue_core
   import terq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_cmd,
   input  wire logic [WORD_W-1:0]     req_control_word,
   input  wire logic [TIME_W-1:0]     req_event_time_us,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [WORD_W-1:0]          rsp_current_control,
   output logic [TIME_W-1:0]          rsp_render_time_us,
   output logic [COUNT_W-1:0]         rsp_applied_now,
   output logic [COUNT_W-1:0]         rsp_late_now,
   output logic [COUNT_W-1:0]         rsp_queue_count,
   output logic [COUNT_W-1:0]         rsp_peak_count,
   output logic                       rsp_overrun,
   output logic [TOTAL_W-1:0]         rsp_overrun_total,
   output logic [TOTAL_W-1:0]         rsp_late_total,
   output logic [TOTAL_W-1:0]         rsp_received_total,
   output logic [TOTAL_W-1:0]         rsp_applied_total,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   terq_cmd_type    cmd;
   terq_status_type status;

   terq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   terq_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_control_word    (req_control_word),
      .req_event_time_us   (req_event_time_us),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_current_control (rsp_current_control),
      .rsp_render_time_us  (rsp_render_time_us),
      .rsp_applied_now     (rsp_applied_now),
      .rsp_late_now        (rsp_late_now),
      .rsp_queue_count     (rsp_queue_count),
      .rsp_peak_count      (rsp_peak_count),
      .rsp_overrun         (rsp_overrun),
      .rsp_overrun_total   (rsp_overrun_total),
      .rsp_late_total      (rsp_late_total),
      .rsp_received_total  (rsp_received_total),
      .rsp_applied_total   (rsp_applied_total)
   );

endmodule

`default_nettype wire
